@@ src/spi_ts_pkg.sv @@
// Shared types, codes and constants of the SPI transaction sequencer.
package spi_ts_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int SIZE_BITS_DEF   = 12;
  localparam int LEN_PORT_W      = 12;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int S_TDATA_W       = 56;
  localparam int M_TDATA_W       = 48;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [1:0] KIND_ENQUEUE  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_WRITE_READ = 2'd2;

  localparam logic [2:0] ACT_ASSERT   = 3'd0;
  localparam logic [2:0] ACT_DEASSERT = 3'd1;
  localparam logic [2:0] ACT_WRITE    = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_DONE     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ERROR   = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef enum logic [2:0] {
    S_CMD,
    S_BEGIN,
    S_START_WR,
    S_START_RD,
    S_FINISH,
    S_FETCH,
    S_RELEASE,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [4:0]            word_bits;
    logic [LEN_PORT_W-1:0] rx_size;
    logic [LEN_PORT_W-1:0] tx_size;
    logic                  cs_hold;
    logic [15:0]           cs_pin;
    logic [3:0]            cs_port;
    logic [1:0]            operation;
    logic [3:0]            tag;
  } desc_t;

  typedef struct packed {
    logic [1:0] kind;
    desc_t      desc;
  } cmd_t;

  typedef struct packed {
    logic [2:0]            action;
    logic [3:0]            out_tag;
    logic [3:0]            out_port;
    logic [15:0]           out_pin;
    logic [LEN_PORT_W-1:0] length;
    logic [4:0]            out_bits;
    logic [1:0]            status;
  } result_t;

endpackage

@@ src/spi_ts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spi_ts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/spi_ts_front.sv @@
// Front end: accepts input transactions, drops unknown kinds and queues commands.
module spi_ts_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [spi_ts_pkg::S_TDATA_W-1:0] s_tdata,  // tag, operation, cs_port, cs_pin,
                                                     // cs_hold, tx_size, rx_size, word_bits
  input  logic [1:0]                        s_tuser,  // kind
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output spi_ts_pkg::cmd_t                  cmd
);
  import spi_ts_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             cmdq [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             in_cmd;
  logic             push;
  logic             pop;

  always_comb begin
    in_cmd.kind                = s_tuser;
    in_cmd.desc.tag            = s_tdata[3:0];
    in_cmd.desc.operation      = s_tdata[5:4];
    in_cmd.desc.cs_port        = s_tdata[9:6];
    in_cmd.desc.cs_pin         = s_tdata[25:10];
    in_cmd.desc.cs_hold        = s_tdata[26];
    in_cmd.desc.tx_size        = s_tdata[38:27];
    in_cmd.desc.rx_size        = s_tdata[50:39];
    in_cmd.desc.word_bits      = s_tdata[55:51];
  end

  assign s_tready  = (count != CNT_W'(CMDQ_DEPTH));
  assign push      = s_tvalid && s_tready &&
                     (s_tuser == KIND_ENQUEUE || s_tuser == KIND_COMPLETE ||
                      s_tuser == KIND_ERROR);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = cmdq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmdq[wr_ptr] <= in_cmd;
    end
  end

endmodule

@@ src/spi_ts_back.sv @@
// Back end: transaction state machine, pending descriptor queue and result staging.
module spi_ts_back #(
  parameter int QUEUE_DEPTH = spi_ts_pkg::QUEUE_DEPTH_DEF,
  parameter int SIZE_BITS   = spi_ts_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  spi_ts_pkg::cmd_t    cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output spi_ts_pkg::result_t res,
  output logic                res_last
);
  import spi_ts_pkg::*;

  localparam int LEN_W   = (SIZE_BITS < LEN_PORT_W) ? SIZE_BITS : LEN_PORT_W;
  localparam int ENTRY_W = 32 + 2 * LEN_W;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TX_LO   = 27;
  localparam int RX_LO   = TX_LO + LEN_W;
  localparam int BITS_LO = RX_LO + LEN_W;

  function automatic result_t mk_res(input logic [2:0] act, input logic [3:0] tag,
                                     input logic [3:0] port, input logic [15:0] pin,
                                     input logic [LEN_PORT_W-1:0] len,
                                     input logic [4:0] bits, input logic [1:0] stat);
    result_t r;
    r.action   = act;
    r.out_tag  = tag;
    r.out_port = port;
    r.out_pin  = pin;
    r.length   = len;
    r.out_bits = bits;
    r.status   = stat;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t                state, state_next;
  phase_t                phase, phase_next;
  logic [PTR_W-1:0]      q_rp, q_rp_next;
  logic [PTR_W-1:0]      q_wp, q_wp_next;
  logic [QCNT_W-1:0]     q_count, q_count_next;
  desc_t                 active, active_next;
  logic                  act_err, act_err_next;
  logic                  sel, sel_next;
  logic                  pend_valid;
  result_t               pend;
  logic [RES_CNT_W-1:0]  res_cnt;
  logic                  emit;
  result_t               em;
  logic                  ram_we, ram_re;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  desc_t                 cmd_desc_m;
  desc_t                 rd_desc;
  logic [LEN_PORT_W-1:0] start_len;
  logic                  emit_keep, need_push, out_free, push, advance;

  always_comb begin
    cmd_desc_m         = cmd.desc;
    cmd_desc_m.tx_size = LEN_PORT_W'(cmd.desc.tx_size[LEN_W-1:0]);
    cmd_desc_m.rx_size = LEN_PORT_W'(cmd.desc.rx_size[LEN_W-1:0]);
    ram_wdata = {cmd.desc.word_bits, cmd.desc.rx_size[LEN_W-1:0],
                 cmd.desc.tx_size[LEN_W-1:0], cmd.desc.cs_hold, cmd.desc.cs_pin,
                 cmd.desc.cs_port, cmd.desc.operation, cmd.desc.tag};
    rd_desc.tag       = ram_rdata[3:0];
    rd_desc.operation = ram_rdata[5:4];
    rd_desc.cs_port   = ram_rdata[9:6];
    rd_desc.cs_pin    = ram_rdata[25:10];
    rd_desc.cs_hold   = ram_rdata[26];
    rd_desc.tx_size   = LEN_PORT_W'(ram_rdata[TX_LO +: LEN_W]);
    rd_desc.rx_size   = LEN_PORT_W'(ram_rdata[RX_LO +: LEN_W]);
    rd_desc.word_bits = ram_rdata[BITS_LO +: 5];
  end

  spi_ts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(PTR_W)
  ) u_queue (
    .clk    (clk),
    .wr_en  (ram_we && advance),
    .wr_addr(q_wp),
    .wr_data(ram_wdata),
    .rd_en  (ram_re && advance),
    .rd_addr(q_rp),
    .rd_data(ram_rdata)
  );

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    q_rp_next    = q_rp;
    q_wp_next    = q_wp;
    q_count_next = q_count;
    active_next  = active;
    act_err_next = act_err;
    sel_next     = sel;
    emit         = 1'b0;
    em           = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    cmd_ready    = 1'b0;
    start_len    = (state == S_START_RD) ? active.rx_size : active.tx_size;
    case (state)
      S_CMD: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.kind)
            KIND_ENQUEUE: begin
              if (q_count == QCNT_W'(QUEUE_DEPTH)) begin
                emit       = 1'b1;
                em         = mk_res(ACT_DONE, cmd.desc.tag, '0, '0, '0, '0, STAT_DROPPED);
                state_next = S_FLUSH;
              end else if (phase != PH_IDLE) begin
                ram_we       = 1'b1;
                q_wp_next    = ptr_inc(q_wp);
                q_count_next = q_count + 1'b1;
              end else begin
                active_next = cmd_desc_m;
                sel_next    = 1'b0;
                state_next  = S_BEGIN;
              end
            end
            KIND_COMPLETE: begin
              if (phase != PH_IDLE) begin
                if (phase == PH_WRITE && active.operation == OP_WRITE_READ) begin
                  state_next = S_START_RD;
                end else begin
                  state_next = S_FINISH;
                end
              end
            end
            KIND_ERROR: begin
              if (phase != PH_IDLE) begin
                act_err_next = 1'b1;
                state_next   = S_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      S_BEGIN: begin
        act_err_next = 1'b0;
        if (active.cs_port == '0 || active.cs_pin == '0) begin
          act_err_next = 1'b1;
          state_next   = S_FINISH;
        end else begin
          emit     = 1'b1;
          em       = mk_res(ACT_ASSERT, active.tag, active.cs_port, active.cs_pin,
                            '0, '0, STAT_OK);
          sel_next = 1'b1;
          case (active.operation)
            OP_WRITE, OP_WRITE_READ: state_next = S_START_WR;
            OP_READ:                 state_next = S_START_RD;
            default: begin
              act_err_next = 1'b1;
              state_next   = S_FINISH;
            end
          endcase
        end
      end
      S_START_WR, S_START_RD: begin
        if (start_len == '0) begin
          act_err_next = 1'b1;
          state_next   = S_FINISH;
        end else begin
          emit       = 1'b1;
          em         = mk_res((state == S_START_RD) ? ACT_READ : ACT_WRITE, active.tag,
                              '0, '0, start_len, active.word_bits, STAT_OK);
          phase_next = (state == S_START_RD) ? PH_READ : PH_WRITE;
          state_next = S_FLUSH;
        end
      end
      S_FINISH: begin
        emit = 1'b1;
        em   = mk_res(ACT_DONE, active.tag, '0, '0, '0, '0,
                      act_err ? STAT_ERROR : STAT_OK);
        if (q_count != '0) begin
          ram_re       = 1'b1;
          q_rp_next    = ptr_inc(q_rp);
          q_count_next = q_count - 1'b1;
          state_next   = S_FETCH;
        end else begin
          state_next = S_RELEASE;
        end
      end
      S_FETCH: begin
        if (sel && (!active.cs_hold || rd_desc.cs_port != active.cs_port ||
                    rd_desc.cs_pin != active.cs_pin)) begin
          emit = 1'b1;
          em   = mk_res(ACT_DEASSERT, active.tag, active.cs_port, active.cs_pin,
                        '0, '0, STAT_OK);
        end
        sel_next    = 1'b0;
        phase_next  = PH_IDLE;
        active_next = rd_desc;
        state_next  = S_BEGIN;
      end
      S_RELEASE: begin
        if (sel) begin
          emit = 1'b1;
          em   = mk_res(ACT_DEASSERT, active.tag, active.cs_port, active.cs_pin,
                        '0, '0, STAT_OK);
        end
        sel_next   = 1'b0;
        phase_next = PH_IDLE;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_CMD;
      end
      default: begin
        state_next = S_CMD;
      end
    endcase
  end

  assign emit_keep = emit && (res_cnt < RES_CNT_W'(MAX_RESULTS));
  assign need_push = pend_valid && (emit_keep || state == S_FLUSH);
  assign out_free  = !res_valid || res_ready;
  assign push      = need_push && out_free;
  assign advance   = !need_push || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CMD;
      phase   <= PH_IDLE;
      q_rp    <= '0;
      q_wp    <= '0;
      q_count <= '0;
      act_err <= 1'b0;
      sel     <= 1'b0;
    end else if (advance) begin
      state   <= state_next;
      phase   <= phase_next;
      q_rp    <= q_rp_next;
      q_wp    <= q_wp_next;
      q_count <= q_count_next;
      act_err <= act_err_next;
      sel     <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_cnt    <= '0;
    end else if (advance) begin
      if (state == S_FLUSH) begin
        pend_valid <= 1'b0;
        res_cnt    <= '0;
      end else if (emit_keep) begin
        pend_valid <= 1'b1;
        res_cnt    <= res_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit_keep && state != S_FLUSH) begin
      pend <= em;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res      <= pend;
      res_last <= (state == S_FLUSH);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("pending queue count exceeds its depth");

  a_select_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMD) |-> (sel == (phase != PH_IDLE)))
    else $error("chip select state disagrees with the phase between transactions");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMD && phase == PH_IDLE) |-> (q_count == '0))
    else $error("pending entries left while no transaction is active");

  a_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMD) |-> !pend_valid)
    else $error("held result not delivered before the next command");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count exceeds its limit");

endmodule

@@ src/spi_transaction_sequencer_core.sv @@
// Top level of the SPI transaction sequencer: front end, back end and port packing.
//
// Channel  Direction  Handshake          Contents
// s_*      in         s_tvalid/s_tready  descriptor or shift engine event, kind in s_tuser
// m_*      out        m_tvalid/m_tready  chip select, start and done actions, m_tlast on final
//
// An enqueue that finds a transaction active is stored in the pending queue without leaving the command state.
// A transaction that starts passes in order through command, chip select, start and result flush.
// Each further entry of a completion chain passes through fetch, chip select,
// an optional start, then a done or the flush, in the order of the state machine, after the
// registered read of the pending queue memory.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled output holds the state machine; two commands queue in front of it meanwhile.
module spi_transaction_sequencer_core #(
  parameter int QUEUE_DEPTH = spi_ts_pkg::QUEUE_DEPTH_DEF,
  parameter int SIZE_BITS   = spi_ts_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [spi_ts_pkg::S_TDATA_W-1:0] s_tdata,  // tag, operation, cs_port, cs_pin,
                                                     // cs_hold, tx_size, rx_size, word_bits
  input  logic [1:0]                        s_tuser,  // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [spi_ts_pkg::M_TDATA_W-1:0] m_tdata,  // out_tag, out_port, out_pin, length,
                                                     // out_bits, status, zero fill
  output logic [2:0]                        m_tuser,  // action
  output logic                              m_tlast
);
  import spi_ts_pkg::*;

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t res;

  spi_ts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  spi_ts_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res),
    .res_last (m_tlast)
  );

  assign m_tdata = {5'b0, res.status, res.out_bits, res.length, res.out_pin,
                    res.out_port, res.out_tag};
  assign m_tuser = res.action;

endmodule
